// ===== rtl/jdn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jdn_pkg;

	localparam int JDN_W   = 23;
	localparam int YEAR_W  = 15;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WDAY_W  = 3;

	localparam logic [JDN_W-1:0] JDN_MAX        = 23'd5373484;
	localparam logic [JDN_W-1:0] GREG_START_JDN = 23'd2299161;

	localparam logic signed [YEAR_W-1:0] YEAR_MIN  = -15'sd4712;
	localparam logic signed [YEAR_W-1:0] YEAR_MAX  = 15'sd9999;
	localparam logic signed [YEAR_W-1:0] GREG_YEAR = 15'sd1582;

	// reciprocal multipliers: q = (x * K) >> S, K = ceil(2^S / D), S = bits(x) + clog2(D)
	localparam int          ALPHA_SHIFT  = 42;
	localparam logic [63:0] ALPHA_K_FULL = ((64'd1 << ALPHA_SHIFT) + 64'd146096) / 64'd146097;
	localparam logic [24:0] ALPHA_K      = ALPHA_K_FULL[24:0];

	localparam int          C_SHIFT  = 40;
	localparam logic [63:0] C_K_FULL = ((64'd1 << C_SHIFT) + 64'd7304) / 64'd7305;
	localparam logic [27:0] C_K      = C_K_FULL[27:0];

	localparam int          Q100_SHIFT  = 21;
	localparam logic [63:0] Q100_K_FULL = ((64'd1 << Q100_SHIFT) + 64'd99) / 64'd100;
	localparam logic [14:0] Q100_K      = Q100_K_FULL[14:0];

	// floor(30.6001 * k)
	function automatic logic [8:0] month_span(input logic [3:0] k);
		logic [8:0] v;
		unique case (k)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd30;
			4'd2:    v = 9'd61;
			4'd3:    v = 9'd91;
			4'd4:    v = 9'd122;
			4'd5:    v = 9'd153;
			4'd6:    v = 9'd183;
			4'd7:    v = 9'd214;
			4'd8:    v = 9'd244;
			4'd9:    v = 9'd275;
			4'd10:   v = 9'd306;
			4'd11:   v = 9'd336;
			4'd12:   v = 9'd367;
			4'd13:   v = 9'd397;
			4'd14:   v = 9'd428;
			4'd15:   v = 9'd459;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// 8 = 1 mod 7: sum the octal digits, then fold
	function automatic logic [WDAY_W-1:0] mod7(input logic [23:0] x);
		logic [5:0] s;
		logic [3:0] t;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 6'(x[3*i +: 3]);
		end
		t = 4'(s[5:3]) + 4'(s[2:0]);
		if (t >= 4'd14) begin
			t = t - 4'd14;
		end else if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[2:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/julian_day_number_converter.sv =====
// Channel  Signals                                         Handshake
// -------  ----------------------------------------------  --------------------------------
// item in  mode, year_in, month_in, day_in, jdn_in         taken at clk when start && !busy
// result   jdn_out, year_out, month_out, day_out,          valid for one cycle while done;
//          weekday, range_error                            receiver cannot stall
//
// Four-stage pipeline after the input register: one item per cycle, busy always low.
// done rises once the item has passed stages 2, 3, 4 and the result register; the depth
// is set by the multiply chain on the day-number-to-date path (alpha and year reciprocals, year start).
// Reset clears only the valid pipeline; payload registers are not reset.
// No backpressure: every accepted item yields exactly one result strobe.
`timescale 1ns / 1ps
`default_nettype none

module julian_day_number_converter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic                               mode,
	input  wire logic signed [jdn_pkg::YEAR_W-1:0]  year_in,
	input  wire logic        [jdn_pkg::MONTH_W-1:0] month_in,
	input  wire logic        [jdn_pkg::DAY_W-1:0]   day_in,
	input  wire logic        [jdn_pkg::JDN_W-1:0]   jdn_in,
	output      logic                               done,
	output      logic        [jdn_pkg::JDN_W-1:0]   jdn_out,
	output      logic signed [jdn_pkg::YEAR_W-1:0]  year_out,
	output      logic        [jdn_pkg::MONTH_W-1:0] month_out,
	output      logic        [jdn_pkg::DAY_W-1:0]   day_out,
	output      logic        [jdn_pkg::WDAY_W-1:0]  weekday,
	output      logic                               range_error
);
	import jdn_pkg::*;

	// stage 1: input register
	logic                      vld_s1, mode_s1;
	logic signed [YEAR_W-1:0]  year_s1;
	logic        [MONTH_W-1:0] month_s1;
	logic        [DAY_W-1:0]   day_s1;
	logic        [JDN_W-1:0]   jdn_s1;

	// stage 1 -> 2 logic
	logic                      bad_date_a, greg_a, bad_jdn_a, gflag_a;
	logic signed [YEAR_W-1:0]  y0_a, ym_a;
	logic        [MONTH_W-1:0] m_a;
	logic        [13:0]        yp_a, yq_op_a;
	logic        [24:0]        t1_a;
	logic        [28:0]        q100_prod_a;
	logic        [23:0]        ax_a;
	logic        [48:0]        alpha_prod_a;
	logic        [6:0]         alpha_a;
	logic        [JDN_W-1:0]   a_a, bb_a;

	// stage 2
	logic                      vld_s2, mode_s2, err_s2, greg_s2;
	logic        [JDN_W-1:0]   t1q_s2, jdn_s2, bb_s2;
	logic        [6:0]         q100_s2;
	logic        [8:0]         mt_s2;
	logic        [DAY_W-1:0]   day_s2;
	logic        [WDAY_W-1:0]  wd1_s2;

	// stage 2 -> 3 logic
	logic        [JDN_W-1:0]   n_b;
	logic        [26:0]        cx_b;
	logic        [54:0]        c_prod_b;

	// stage 3
	logic                      vld_s3, mode_s3, err_s3;
	logic        [JDN_W-1:0]   n_s3, jdn_s3, bb_s3;
	logic        [13:0]        c_s3;
	logic        [WDAY_W-1:0]  wd1_s3;

	// stage 3 -> 4 logic
	logic        [24:0]        d_c;
	logic        [JDN_W-1:0]   dd23_c;

	// stage 4
	logic                      vld_s4, mode_s4, err_s4;
	logic        [JDN_W-1:0]   n_s4, jdn_s4;
	logic        [13:0]        c_s4;
	logic        [9:0]         r_s4;
	logic        [WDAY_W-1:0]  wd0_s4, wd1_s4;

	// stage 4 -> out logic
	logic        [3:0]         e_d;
	logic        [9:0]         dd_d;
	logic        [MONTH_W-1:0] mo_d;
	logic signed [YEAR_W-1:0]  yr_d;

	// result registers
	logic                      done_q, err_q;
	logic        [JDN_W-1:0]   jdn_q;
	logic signed [YEAR_W-1:0]  year_q;
	logic        [MONTH_W-1:0] month_q;
	logic        [DAY_W-1:0]   day_q;
	logic        [WDAY_W-1:0]  wd_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1  <= mode;
			year_s1  <= year_in;
			month_s1 <= month_in;
			day_s1   <= day_in;
			jdn_s1   <= jdn_in;
		end
	end

	// date prep, alpha correction for the Gregorian range
	always_comb begin
		bad_date_a = (month_s1 == '0) || (month_s1 > 4'd12) || (day_s1 == '0) ||
			(year_s1 == '0) || (year_s1 < YEAR_MIN) || (year_s1 > YEAR_MAX);
		y0_a = year_s1[YEAR_W-1] ? year_s1 + 15'sd1 : year_s1;
		if (month_s1 <= 4'd2) begin
			ym_a = y0_a - 15'sd1;
			m_a  = month_s1 + 4'd12;
		end else begin
			ym_a = y0_a;
			m_a  = month_s1;
		end
		greg_a = (ym_a > GREG_YEAR) || ((ym_a == GREG_YEAR) &&
			((m_a > 4'd10) || ((m_a == 4'd10) && (day_s1 >= 5'd15))));
		yp_a        = 14'(ym_a + 15'sd4716);
		t1_a        = 25'(yp_a) * 25'd1461;
		yq_op_a     = greg_a ? ym_a[13:0] : '0;
		q100_prod_a = 29'(yq_op_a) * 29'(Q100_K);

		bad_jdn_a    = jdn_s1 > JDN_MAX;
		gflag_a      = jdn_s1 >= GREG_START_JDN;
		ax_a         = 24'({jdn_s1, 2'b00} - 25'd7468865);
		alpha_prod_a = 49'(ax_a) * 49'(ALPHA_K);
		alpha_a      = alpha_prod_a[ALPHA_SHIFT +: 7];
		a_a          = gflag_a ? jdn_s1 + 23'd1 + 23'(alpha_a) - 23'(alpha_a[6:2]) : jdn_s1;
		bb_a         = a_a + 23'd1524;
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		err_s2  <= mode_s1 ? bad_jdn_a : bad_date_a;
		greg_s2 <= greg_a;
		t1q_s2  <= t1_a[24:2];
		q100_s2 <= q100_prod_a[Q100_SHIFT +: 7];
		mt_s2   <= month_span(4'(m_a + 4'd1));
		day_s2  <= day_s1;
		jdn_s2  <= jdn_s1;
		bb_s2   <= bb_a;
		wd1_s2  <= mod7(24'(jdn_s1) + 24'd1);
	end

	always_comb begin
		n_b = t1q_s2 + 23'(mt_s2) + 23'(day_s2) - 23'd1524 +
			(greg_s2 ? 23'd2 + 23'(q100_s2[6:2]) - 23'(q100_s2) : '0);
		cx_b     = 27'({bb_s2, 4'b0000}) + 27'({bb_s2, 2'b00}) - 27'd2442;
		c_prod_b = 55'(cx_b) * 55'(C_K);
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		err_s3  <= err_s2;
		n_s3    <= n_b;
		jdn_s3  <= jdn_s2;
		bb_s3   <= bb_s2;
		c_s3    <= c_prod_b[C_SHIFT +: 14];
		wd1_s3  <= wd1_s2;
	end

	always_comb begin
		d_c    = 25'(c_s3) * 25'd1461;
		dd23_c = bb_s3 - d_c[24:2];
	end

	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		err_s4  <= err_s3;
		n_s4    <= n_s3;
		jdn_s4  <= jdn_s3;
		c_s4    <= c_s3;
		r_s4    <= dd23_c[9:0];
		wd0_s4  <= mod7(24'(n_s3) + 24'd1);
		wd1_s4  <= wd1_s3;
	end

	// month index e: count of month boundaries below r
	always_comb begin
		e_d = '0;
		for (int k = 1; k < 16; k++) begin
			if (r_s4 > 10'(month_span(4'(k)))) begin
				e_d = e_d + 4'd1;
			end
		end
		dd_d = r_s4 - 10'(month_span(e_d));
		mo_d = (e_d < 4'd14) ? e_d - 4'd1 : e_d - 4'd13;
		yr_d = $signed({1'b0, c_s4}) - ((mo_d > 4'd2) ? 15'sd4716 : 15'sd4715);
		if (yr_d <= 15'sd0) begin
			yr_d = yr_d - 15'sd1;
		end
	end

	always_ff @(posedge clk) begin
		if (err_s4) begin
			err_q   <= 1'b1;
			jdn_q   <= '0;
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			wd_q    <= '0;
		end else if (!mode_s4) begin
			err_q   <= 1'b0;
			jdn_q   <= n_s4;
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			wd_q    <= wd0_s4;
		end else begin
			err_q   <= 1'b0;
			jdn_q   <= jdn_s4;
			year_q  <= yr_d;
			month_q <= mo_d;
			day_q   <= dd_d[DAY_W-1:0];
			wd_q    <= wd1_s4;
		end
	end

	assign done        = done_q;
	assign range_error = err_q;
	assign jdn_out     = jdn_q;
	assign year_out    = year_q;
	assign month_out   = month_q;
	assign day_out     = day_q;
	assign weekday     = wd_q;

endmodule

`default_nettype wire

// ===== rtl/jdn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jdn_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic                               done,
	input wire logic        [jdn_pkg::JDN_W-1:0]   jdn_out,
	input wire logic signed [jdn_pkg::YEAR_W-1:0]  year_out,
	input wire logic        [jdn_pkg::MONTH_W-1:0] month_out,
	input wire logic        [jdn_pkg::DAY_W-1:0]   day_out,
	input wire logic        [jdn_pkg::WDAY_W-1:0]  weekday,
	input wire logic                               range_error
);
	import jdn_pkg::*;

	// every accepted item is followed by a done strobe
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##5 done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without accepted item");

	a_err_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_error |-> jdn_out == '0 && year_out == '0 && month_out == '0 &&
			day_out == '0 && weekday == '0)
		else $error("range error with nonzero fields");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		done && !range_error && month_out != '0 |->
			month_out <= 4'd12 && day_out != '0 && year_out != '0 && weekday < 3'd7)
		else $error("converted date out of range");

endmodule

bind julian_day_number_converter jdn_checker u_jdn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.jdn_out     (jdn_out),
	.year_out    (year_out),
	.month_out   (month_out),
	.day_out     (day_out),
	.weekday     (weekday),
	.range_error (range_error)
);

`default_nettype wire
